[hdl/ghe_pkg.sv]
package ghe_pkg;

  localparam int LngW  = 33;
  localparam int LatW  = 32;
  localparam int StepW = 6;
  localparam int HashW = 64;
  localparam int IdxW  = 32;            // widest per-axis cell index
  localparam int RemW  = 34;            // divider remainder, holds up to 2 * scale
  localparam int ProdW = 66;            // (index + 1) * scale
  localparam int CfgW  = 33;

  localparam logic signed [LngW-1:0] LngLimit = 33'sd3019898880;
  localparam logic signed [LatW-1:0] LatLimit = 32'sd1509949440;

  typedef enum logic {
    KindEncode = 1'b0,
    KindDecode = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    RegMinLng = 2'd0,
    RegMaxLng = 2'd1,
    RegMinLat = 2'd2,
    RegMaxLat = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             vld;
    kind_t            kind;
    logic             ok;
    logic [StepW-1:0] step;
    logic             sat_lng;
    logic             sat_lat;
    logic [RemW-1:0]  r_lng;
    logic [RemW-1:0]  r_lat;
    logic [IdxW-1:0]  q_lng;
    logic [IdxW-1:0]  q_lat;
    logic [IdxW-1:0]  ilng;
    logic [IdxW-1:0]  ilat;
    logic [ProdW-1:0] p_lng_lo;
    logic [ProdW-1:0] p_lng_hi;
    logic [ProdW-1:0] p_lat_lo;
    logic [ProdW-1:0] p_lat_hi;
  } stage_t;

endpackage

[hdl/ghe_if.sv]
interface ghe_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [32:0]       point_lng;
  logic signed [31:0]       point_lat;
  logic [5:0]               precision_step;
  logic [63:0]              hash_in;

  modport source (output valid, kind, point_lng, point_lat, precision_step, hash_in,
                  input ready);
  modport sink   (input valid, kind, point_lng, point_lat, precision_step, hash_in,
                  output ready);
endinterface

interface ghe_out_if;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic [63:0]              hash_out;
  logic signed [31:0]       cell_min_lat;
  logic signed [31:0]       cell_max_lat;
  logic signed [32:0]       cell_min_lng;
  logic signed [32:0]       cell_max_lng;

  modport source (output valid, ok, hash_out, cell_min_lat, cell_max_lat, cell_min_lng,
                  cell_max_lng, input ready);
  modport sink   (input valid, ok, hash_out, cell_min_lat, cell_max_lat, cell_min_lng,
                  cell_max_lng, output ready);
endinterface

[hdl/ghe_div_stage.sv]
// One restoring-divide step per axis; the first stage also forms the decode products.
module ghe_div_stage #(
  parameter int ITER = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [ghe_pkg::LngW-1:0]      scale_lng,
  input  logic [ghe_pkg::LngW-1:0]      scale_lat,
  input  ghe_pkg::stage_t               d,
  output ghe_pkg::stage_t               q
);

  ghe_pkg::stage_t           nxt;
  logic [ghe_pkg::RemW:0]    r2_lng;
  logic [ghe_pkg::RemW:0]    r2_lat;
  logic                      active;

  always_comb begin
    nxt    = d;
    active = (ghe_pkg::StepW'(ITER) < d.step);
    r2_lng = {d.r_lng, 1'b0};
    r2_lat = {d.r_lat, 1'b0};
    if (active && !d.sat_lng) begin
      if (r2_lng >= (ghe_pkg::RemW+1)'(scale_lng)) begin
        nxt.r_lng = ghe_pkg::RemW'(r2_lng - (ghe_pkg::RemW+1)'(scale_lng));
        nxt.q_lng = {d.q_lng[ghe_pkg::IdxW-2:0], 1'b1};
      end else begin
        nxt.r_lng = ghe_pkg::RemW'(r2_lng);
        nxt.q_lng = {d.q_lng[ghe_pkg::IdxW-2:0], 1'b0};
      end
    end
    if (active && !d.sat_lat) begin
      if (r2_lat >= (ghe_pkg::RemW+1)'(scale_lat)) begin
        nxt.r_lat = ghe_pkg::RemW'(r2_lat - (ghe_pkg::RemW+1)'(scale_lat));
        nxt.q_lat = {d.q_lat[ghe_pkg::IdxW-2:0], 1'b1};
      end else begin
        nxt.r_lat = ghe_pkg::RemW'(r2_lat);
        nxt.q_lat = {d.q_lat[ghe_pkg::IdxW-2:0], 1'b0};
      end
    end
    if (ITER == 0) begin
      nxt.p_lng_lo = {1'b0, d.ilng} * scale_lng;
      nxt.p_lng_hi = ({1'b0, d.ilng} + 33'd1) * scale_lng;
      nxt.p_lat_lo = {1'b0, d.ilat} * scale_lat;
      nxt.p_lat_hi = ({1'b0, d.ilat} + 33'd1) * scale_lat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.kind     <= nxt.kind;
      q.ok       <= nxt.ok;
      q.step     <= nxt.step;
      q.sat_lng  <= nxt.sat_lng;
      q.sat_lat  <= nxt.sat_lat;
      q.r_lng    <= nxt.r_lng;
      q.r_lat    <= nxt.r_lat;
      q.q_lng    <= nxt.q_lng;
      q.q_lat    <= nxt.q_lat;
      q.ilng     <= nxt.ilng;
      q.ilat     <= nxt.ilat;
      q.p_lng_lo <= nxt.p_lng_lo;
      q.p_lng_hi <= nxt.p_lng_hi;
      q.p_lat_lo <= nxt.p_lat_lo;
      q.p_lat_hi <= nxt.p_lat_hi;
    end
  end

endmodule

[hdl/geohash_encode_decode.sv]
// Geohash encoder/decoder on 2^-24 degree fixed point. Each input word is an
// encode (point to interleaved hash, latitude in even bits) or a decode (hash to
// cell edges), and yields exactly one output word. The pipeline takes a new word
// every cycle while the output word is not held. It has one input/check stage, one
// restoring-divide stage per index bit (the first also holds the decode
// multipliers), and the output register. The whole pipeline stalls as one when
// the output word is held. The range registers are read live by the pipeline,
// so write them only while no word is in flight.
module geohash_encode_decode #(
  parameter int MAX_PRECISION = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [ghe_pkg::CfgW-1:0]   cfg_data,
  ghe_in_if.sink                     in_ch,
  ghe_out_if.source                  out_ch
);

  // Range registers.
  logic signed [ghe_pkg::LngW-1:0] min_lng, max_lng;
  logic signed [ghe_pkg::LatW-1:0] min_lat, max_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_lng <= -ghe_pkg::LngLimit;
      max_lng <= ghe_pkg::LngLimit;
      min_lat <= -ghe_pkg::LatLimit;
      max_lat <= ghe_pkg::LatLimit;
    end else if (cfg_we) begin
      unique case (ghe_pkg::reg_idx_t'(cfg_index))
        ghe_pkg::RegMinLng: min_lng <= cfg_data;
        ghe_pkg::RegMaxLng: max_lng <= cfg_data;
        ghe_pkg::RegMinLat: min_lat <= cfg_data[ghe_pkg::LatW-1:0];
        ghe_pkg::RegMaxLat: max_lat <= cfg_data[ghe_pkg::LatW-1:0];
        default: ;
      endcase
    end
  end

  // Rectangle spans; only meaningful when the rectangle is non-empty.
  logic                           empty;
  logic [ghe_pkg::RemW-1:0]       span_lng, span_lat;
  logic [ghe_pkg::LngW-1:0]       scale_lng, scale_lat;

  assign empty     = (max_lng <= min_lng) || (max_lat <= min_lat);
  assign span_lng  = ghe_pkg::RemW'(max_lng) - ghe_pkg::RemW'(min_lng);
  assign span_lat  = ghe_pkg::RemW'(max_lat) - ghe_pkg::RemW'(min_lat);
  assign scale_lng = span_lng[ghe_pkg::LngW-1:0];
  assign scale_lat = span_lat[ghe_pkg::LngW-1:0];

  // Whole-pipeline advance: move when the output slot is free or being taken.
  logic en;
  logic out_vld;

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  // Input stage: argument checks, offsets, de-interleave.
  ghe_pkg::stage_t st [0:MAX_PRECISION];
  ghe_pkg::stage_t s0_next;

  logic [ghe_pkg::RemW-1:0] d_lng, d_lat;
  logic                     on_globe, in_rect, enc_ok, dec_ok;

  always_comb begin
    s0_next      = '0;
    d_lng        = ghe_pkg::RemW'(in_ch.point_lng) - ghe_pkg::RemW'(min_lng);
    d_lat        = ghe_pkg::RemW'(in_ch.point_lat) - ghe_pkg::RemW'(min_lat);
    on_globe     = (in_ch.point_lng <= ghe_pkg::LngLimit) &&
                   (in_ch.point_lng >= -ghe_pkg::LngLimit) &&
                   (in_ch.point_lat <= ghe_pkg::LatLimit) &&
                   (in_ch.point_lat >= -ghe_pkg::LatLimit);
    in_rect      = (in_ch.point_lng >= min_lng) && (in_ch.point_lng <= max_lng) &&
                   (in_ch.point_lat >= min_lat) && (in_ch.point_lat <= max_lat);
    enc_ok       = !empty && on_globe && in_rect && (in_ch.precision_step != '0) &&
                   (in_ch.precision_step <= ghe_pkg::StepW'(MAX_PRECISION));
    dec_ok       = !empty && (in_ch.precision_step <= ghe_pkg::StepW'(MAX_PRECISION)) &&
                   !((in_ch.hash_in == '0) && (in_ch.precision_step == '0));
    s0_next.vld  = in_ch.valid;
    s0_next.kind = ghe_pkg::kind_t'(in_ch.kind);
    s0_next.ok   = (in_ch.kind == ghe_pkg::KindDecode) ? dec_ok : enc_ok;
    s0_next.step = in_ch.precision_step;
    // Hold the offset as the first partial remainder; saturate on the far edge.
    s0_next.r_lng   = d_lng;
    s0_next.r_lat   = d_lat;
    s0_next.sat_lng = d_lng >= ghe_pkg::RemW'(scale_lng);
    s0_next.sat_lat = d_lat >= ghe_pkg::RemW'(scale_lat);
    // Drop index bits at or above the step.
    for (int i = 0; i < ghe_pkg::IdxW; i++) begin
      s0_next.ilat[i] = in_ch.hash_in[2*i]   && (ghe_pkg::StepW'(i) < in_ch.precision_step);
      s0_next.ilng[i] = in_ch.hash_in[2*i+1] && (ghe_pkg::StepW'(i) < in_ch.precision_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].vld <= 1'b0;
    end else if (en) begin
      st[0].vld <= s0_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].kind     <= s0_next.kind;
      st[0].ok       <= s0_next.ok;
      st[0].step     <= s0_next.step;
      st[0].sat_lng  <= s0_next.sat_lng;
      st[0].sat_lat  <= s0_next.sat_lat;
      st[0].r_lng    <= s0_next.r_lng;
      st[0].r_lat    <= s0_next.r_lat;
      st[0].q_lng    <= s0_next.q_lng;
      st[0].q_lat    <= s0_next.q_lat;
      st[0].ilng     <= s0_next.ilng;
      st[0].ilat     <= s0_next.ilat;
      st[0].p_lng_lo <= s0_next.p_lng_lo;
      st[0].p_lng_hi <= s0_next.p_lng_hi;
      st[0].p_lat_lo <= s0_next.p_lat_lo;
      st[0].p_lat_hi <= s0_next.p_lat_hi;
    end
  end

  // Divide stages: one quotient bit per stage, per axis.
  for (genvar k = 0; k < MAX_PRECISION; k++) begin : g_div
    ghe_div_stage #(.ITER(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .scale_lng (scale_lng),
      .scale_lat (scale_lat),
      .d         (st[k]),
      .q         (st[k+1])
    );
  end

  // Output stage: interleave for encode, scale back for decode.
  ghe_pkg::stage_t               sl;
  logic [ghe_pkg::IdxW:0]        sat_mask;
  logic [ghe_pkg::IdxW-1:0]      idx_lng, idx_lat;
  logic [ghe_pkg::HashW-1:0]     hash_next;
  logic [ghe_pkg::ProdW-1:0]     sh_lng_lo, sh_lng_hi, sh_lat_lo, sh_lat_hi;
  logic                          ok_next;
  logic                          enc_word, dec_word;
  logic [ghe_pkg::HashW-1:0]     hash_o;
  logic [ghe_pkg::LatW-1:0]      min_lat_o, max_lat_o;
  logic [ghe_pkg::LngW-1:0]      min_lng_o, max_lng_o;
  logic                          ok_o;

  assign sl = st[MAX_PRECISION];

  always_comb begin
    sat_mask  = ((ghe_pkg::IdxW+1)'(1) << sl.step) - (ghe_pkg::IdxW+1)'(1);
    idx_lng   = sl.sat_lng ? sat_mask[ghe_pkg::IdxW-1:0] : sl.q_lng;
    idx_lat   = sl.sat_lat ? sat_mask[ghe_pkg::IdxW-1:0] : sl.q_lat;
    for (int i = 0; i < ghe_pkg::IdxW; i++) begin
      hash_next[2*i]   = idx_lat[i];
      hash_next[2*i+1] = idx_lng[i];
    end
    sh_lng_lo = sl.p_lng_lo >> sl.step;
    sh_lng_hi = sl.p_lng_hi >> sl.step;
    sh_lat_lo = sl.p_lat_lo >> sl.step;
    sh_lat_hi = sl.p_lat_hi >> sl.step;
    ok_next   = sl.ok;
    enc_word  = ok_next && (sl.kind == ghe_pkg::KindEncode);
    dec_word  = ok_next && (sl.kind == ghe_pkg::KindDecode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= sl.vld;
    end
  end

  // Zero every field that the word's kind does not use, and all but the flag on error.
  always_ff @(posedge clk) begin
    if (en) begin
      ok_o      <= ok_next;
      hash_o    <= enc_word ? hash_next : '0;
      min_lat_o <= dec_word ? min_lat + sh_lat_lo[ghe_pkg::LatW-1:0] : '0;
      max_lat_o <= dec_word ? min_lat + sh_lat_hi[ghe_pkg::LatW-1:0] : '0;
      min_lng_o <= dec_word ? min_lng + sh_lng_lo[ghe_pkg::LngW-1:0] : '0;
      max_lng_o <= dec_word ? min_lng + sh_lng_hi[ghe_pkg::LngW-1:0] : '0;
    end
  end

  assign out_ch.valid        = out_vld;
  assign out_ch.ok           = ok_o;
  assign out_ch.hash_out     = hash_o;
  assign out_ch.cell_min_lat = min_lat_o;
  assign out_ch.cell_max_lat = max_lat_o;
  assign out_ch.cell_min_lng = min_lng_o;
  assign out_ch.cell_max_lng = max_lng_o;

endmodule

[hdl/ghe_checker.sv]
module ghe_props (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               ok,
  input logic [63:0]        hash_out,
  input logic signed [31:0] cell_min_lat,
  input logic signed [31:0] cell_max_lat,
  input logic signed [32:0] cell_min_lng,
  input logic signed [32:0] cell_max_lng
);

  // A held word keeps its hash, flag, minimum latitude and maximum longitude.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_out) && $stable(ok) &&
    $stable(cell_min_lat) && $stable(cell_max_lng))
    else $error("output word changed while held");

  // An error word carries nothing but the flag.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> hash_out == '0 && cell_min_lat == '0 && cell_max_lat == '0 &&
    cell_min_lng == '0 && cell_max_lng == '0)
    else $error("error word with nonzero fields");

  // A nonzero hash never comes with a nonzero minimum latitude or maximum longitude.
  a_enc_no_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && hash_out != '0 |-> cell_min_lat == '0 && cell_max_lng == '0)
    else $error("hash and cell edges together");

  // Decoded cells are ordered.
  a_cell_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> cell_min_lat <= cell_max_lat && cell_min_lng <= cell_max_lng)
    else $error("decoded cell edges out of order");

  // A free output side never blocks the input.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with output ready");

endmodule

bind geohash_encode_decode ghe_props u_ghe_props (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .ok           (out_ch.ok),
  .hash_out     (out_ch.hash_out),
  .cell_min_lat (out_ch.cell_min_lat),
  .cell_max_lat (out_ch.cell_max_lat),
  .cell_min_lng (out_ch.cell_min_lng),
  .cell_max_lng (out_ch.cell_max_lng)
);
